FILE: rtl/pls_pkg.sv
// Package for the positional list store: operation codes, sequencer states, constants.
`default_nettype none
package pls_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CHANGE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_WR   = 5'b00100,
        S_PUT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    localparam logic signed [31:0] READ_ERROR_VALUE = -32'sd9999;
    localparam logic [6:0]         LIMIT_RESET      = 7'd64;
    localparam logic               REG_LIMIT        = 1'b0;

endpackage
`default_nettype wire

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: request sequencer, entry RAM and APB register.
`default_nettype none
// Ordered list of signed 32-bit entries held in one RAM with a single write port and a
// single registered read port. A request is taken when start is high and busy is low; its
// result appears for exactly one cycle with o_valid high and cannot be held off. Every
// entry move during insert or delete goes through the one RAM port pair as a read in S_RD
// followed by a write in S_WR, and the result strobes in the same cycle as busy falls. A
// rejected request never raises busy and strobes its result in the cycle after the
// transfer. Entry storage needs no clearing after reset: only positions below the count
// are ever read. The capacity_limit register sits at byte address 0; values above
// CAPACITY act as CAPACITY.
module positional_list_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_op,
    input  wire logic [5:0]         i_position,
    input  wire logic signed [31:0] i_value,
    // result channel
    output logic                    o_valid,
    output logic signed [31:0]      o_read_value,
    output logic                    o_error,
    output logic [6:0]              o_entry_count,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // sequencer and list state
    pls_pkg::t_state   r_state, n_state;
    pls_pkg::t_op      r_op, n_op;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic [CW-1:0]     r_count, n_count;
    logic [6:0]        r_limit;

    // result register
    logic               r_valid, n_valid;
    logic signed [31:0] r_read_value, n_read_value;
    logic               r_error, n_error;
    logic [6:0]         r_out_count, n_out_count;

    // RAM port signals
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [31:0]       w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [31:0]       w_rdata;

    // request checks
    logic [CMPW-1:0]   w_pos_x;
    logic [CMPW-1:0]   w_cnt_x;
    logic [CMPW-1:0]   w_lim_x;
    logic [CMPW-1:0]   w_cap_x;
    logic              w_accept;
    logic              w_ins_bad;
    logic              w_oth_bad;
    logic              w_bad;
    logic [CMPW-1:0]   w_idx_x;

    logic              w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == pls_pkg::REG_LIMIT) ? {25'd0, r_limit} : 32'd0;

    // effective limit is the smaller of the register and the storage depth
    assign w_cap_x = CMPW'(CAPACITY);
    assign w_lim_x = (CMPW'(r_limit) > w_cap_x) ? w_cap_x : CMPW'(r_limit);
    assign w_pos_x = CMPW'(i_position);
    assign w_cnt_x = CMPW'(r_count);

    assign busy      = (r_state != pls_pkg::S_IDLE);
    assign w_accept  = start && !busy;
    assign w_ins_bad = (w_pos_x >= w_lim_x) || (w_cnt_x >= w_lim_x) || (w_pos_x > w_cnt_x);
    assign w_oth_bad = (w_pos_x >= w_cnt_x);
    assign w_bad     = (pls_pkg::t_op'(i_op) == pls_pkg::OP_INSERT) ? w_ins_bad : w_oth_bad;
    assign w_idx_x   = CMPW'(r_idx);

    pls_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // RAM port steering: read the neighbor in S_RD, write it one slot over in S_WR
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_raddr = r_idx;
        unique case (r_state)
            pls_pkg::S_RD: begin
                if (r_op == pls_pkg::OP_INSERT) begin
                    w_raddr = r_idx - AW'(1);
                end else if (r_op == pls_pkg::OP_DELETE) begin
                    w_raddr = r_idx + AW'(1);
                end
            end
            pls_pkg::S_WR: begin
                w_we = (r_op == pls_pkg::OP_INSERT) || (r_op == pls_pkg::OP_DELETE);
            end
            pls_pkg::S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_val;
            end
            pls_pkg::S_IDLE, pls_pkg::S_FIN: begin
                w_we = 1'b0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_val        = r_val;
        n_count      = r_count;
        n_valid      = 1'b0;
        n_read_value = r_read_value;
        n_error      = r_error;
        n_out_count  = r_out_count;
        unique case (r_state)
            pls_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op  = pls_pkg::t_op'(i_op);
                    n_pos = w_pos_x[AW-1:0];
                    n_val = i_value;
                    if (w_bad) begin
                        // reject: list untouched, result goes out next cycle
                        n_valid      = 1'b1;
                        n_error      = 1'b1;
                        n_out_count  = w_cnt_x[6:0];
                        n_read_value = (pls_pkg::t_op'(i_op) == pls_pkg::OP_READ)
                                     ? pls_pkg::READ_ERROR_VALUE : 32'sd0;
                    end else begin
                        unique case (pls_pkg::t_op'(i_op))
                            pls_pkg::OP_INSERT: begin
                                // start at the append slot and walk down to position
                                n_idx   = w_cnt_x[AW-1:0];
                                n_state = (w_cnt_x > w_pos_x) ? pls_pkg::S_RD
                                                              : pls_pkg::S_PUT;
                            end
                            pls_pkg::OP_DELETE: begin
                                n_idx   = w_pos_x[AW-1:0];
                                n_state = ((w_pos_x + CMPW'(1)) < w_cnt_x) ? pls_pkg::S_RD
                                                                           : pls_pkg::S_FIN;
                            end
                            pls_pkg::OP_READ: begin
                                n_idx   = w_pos_x[AW-1:0];
                                n_state = pls_pkg::S_RD;
                            end
                            pls_pkg::OP_CHANGE: begin
                                n_state = pls_pkg::S_PUT;
                            end
                            default: begin
                                n_state = pls_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            pls_pkg::S_RD: begin
                n_state = pls_pkg::S_WR;
            end
            pls_pkg::S_WR: begin
                if (r_op == pls_pkg::OP_INSERT) begin
                    n_idx   = r_idx - AW'(1);
                    n_state = ((w_idx_x - CMPW'(1)) > CMPW'(r_pos)) ? pls_pkg::S_RD
                                                                    : pls_pkg::S_PUT;
                end else if (r_op == pls_pkg::OP_DELETE) begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ((w_idx_x + CMPW'(2)) < w_cnt_x) ? pls_pkg::S_RD
                                                               : pls_pkg::S_FIN;
                end else begin
                    // read: hand out the fetched entry
                    n_state      = pls_pkg::S_IDLE;
                    n_valid      = 1'b1;
                    n_error      = 1'b0;
                    n_read_value = w_rdata;
                    n_out_count  = w_cnt_x[6:0];
                end
            end
            pls_pkg::S_PUT: begin
                n_state      = pls_pkg::S_IDLE;
                n_valid      = 1'b1;
                n_error      = 1'b0;
                n_read_value = 32'sd0;
                if (r_op == pls_pkg::OP_INSERT) begin
                    n_count     = r_count + CW'(1);
                    n_out_count = 7'(w_cnt_x + CMPW'(1));
                end else begin
                    n_out_count = w_cnt_x[6:0];
                end
            end
            pls_pkg::S_FIN: begin
                // drop the last entry
                n_state      = pls_pkg::S_IDLE;
                n_valid      = 1'b1;
                n_error      = 1'b0;
                n_read_value = 32'sd0;
                n_count      = r_count - CW'(1);
                n_out_count  = 7'(w_cnt_x - CMPW'(1));
            end
            default: begin
                n_state = pls_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pls_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_limit <= pls_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (w_cfg_write && (paddr[2] == pls_pkg::REG_LIMIT)) begin
                r_limit <= pwdata[6:0];
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_read_value <= n_read_value;
        r_error      <= n_error;
        r_out_count  <= n_out_count;
    end

    assign o_valid       = r_valid;
    assign o_read_value  = r_read_value;
    assign o_error       = r_error;
    assign o_entry_count = r_out_count;

    // a finished request always strobes its result as busy drops
    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result strobe");

    // the count never exceeds the storage depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // a rejected request leaves the count alone
    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (r_count == $past(r_count)))
        else $error("rejected request changed the count");

    // the RAM is written only while a request is in progress
    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> busy)
        else $error("RAM write outside a request");

endmodule
`default_nettype wire

FILE: rtl/pls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: tb/positional_list_store_test.sv
// Self-checking testbench for the positional list store: directed and random list traffic.
module positional_list_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LIST_DEPTH = 64;
    // Byte addresses on the register port: the limit register, and one unused slot
    // whose writes must be ignored.
    localparam logic [2:0] LIMIT_ADDR  = {pls_pkg::REG_LIMIT, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'd4;
    // Number of random requests in each traffic phase.
    localparam int         PHASE_ITEMS = 235;

    // One result of the list: what a read returned, the reject flag, the entry count.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic               error;
        logic [6:0]         entry_count;
    } t_list_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_op = pls_pkg::OP_READ;
    logic [5:0]         i_position = '0;
    logic signed [31:0] i_value = '0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;

    wire                busy;
    wire                o_valid;
    wire signed [31:0]  o_read_value;
    wire                o_error;
    wire [6:0]          o_entry_count;
    wire [31:0]         prdata;
    wire                pready;

    // Mirror of the list held by the block, plus its limit register.
    logic signed [31:0] list_mirror [0:LIST_DEPTH-1];
    int unsigned        mirror_count = 0;
    logic [6:0]         limit_mirror = pls_pkg::LIMIT_RESET;

    // Results owed by the block, oldest first.
    t_list_result       expected_results [$];

    int                 mismatch_count = 0;
    // Chance in percent that the sender pauses after a transfer.
    int                 idle_pct = 0;
    // Direction of the random walk on the list length.
    bit                 growing = 1'b1;

    positional_list_store #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_error      (o_error),
        .o_entry_count(o_entry_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Limit in force: register values above the list depth act as the depth.
    function automatic int unsigned active_limit();
        return (limit_mirror > LIST_DEPTH) ? LIST_DEPTH : limit_mirror;
    endfunction

    // Apply one request to the mirror and return the result the block owes for it.
    function automatic t_list_result apply_list_request(input pls_pkg::t_op op,
                                                        input logic [5:0] pos,
                                                        input logic signed [31:0] val);
        t_list_result res;
        int unsigned  lim;
        lim = active_limit();
        res = '0;
        case (op)
            pls_pkg::OP_INSERT: begin
                // Reject past the limit, on a full list, or beyond the append slot.
                if (pos >= lim || mirror_count >= lim || pos > mirror_count) begin
                    res.error = 1'b1;
                end else begin
                    for (int i = mirror_count; i > pos; i--)
                        list_mirror[i] = list_mirror[i-1];
                    list_mirror[pos] = val;
                    mirror_count++;
                end
            end
            pls_pkg::OP_DELETE: begin
                if (pos >= mirror_count) begin
                    res.error = 1'b1;
                end else begin
                    for (int i = pos; i + 1 < mirror_count; i++)
                        list_mirror[i] = list_mirror[i+1];
                    mirror_count--;
                end
            end
            pls_pkg::OP_READ: begin
                if (pos >= mirror_count) begin
                    res.error      = 1'b1;
                    res.read_value = pls_pkg::READ_ERROR_VALUE;
                end else begin
                    res.read_value = list_mirror[pos];
                end
            end
            default: begin
                if (pos >= mirror_count)
                    res.error = 1'b1;
                else
                    list_mirror[pos] = val;
            end
        endcase
        res.entry_count = mirror_count[6:0];
        return res;
    endfunction

    // Present one request and hold it until the transfer; start stays high afterwards so
    // that a following request can go out back to back.
    task automatic send_request(input pls_pkg::t_op op, input logic [5:0] pos,
                                input logic signed [31:0] val);
        start      <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        do
            @(posedge i_clk);
        while (busy);
        expected_results.push_back(apply_list_request(op, pos, val));
    endtask

    // Drop start for a random stretch, as often as the current phase asks.
    task automatic sender_pause();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // Hold off until every owed result is in, then give the sequencer time to settle.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register while the list is idle, then read the limit register back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] word);
        drain_results();
        // setup then access phase; the write lands at the access edge
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == LIMIT_ADDR)
            limit_mirror = word[6:0];
        // back-to-back read of the limit register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {25'd0, limit_mirror})
            report_mismatch($sformatf("limit readback %h, expected %h",
                                      prdata, {25'd0, limit_mirror}));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Compare every result strobe against the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              o_read_value, want.read_value));
                if (o_error !== want.error)
                    report_mismatch($sformatf("error %b, expected %b",
                                              o_error, want.error));
                if (o_entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              o_entry_count, want.entry_count));
            end
        end
    end

    // Every access on an empty list is rejected; a read returns the error value.
    task automatic test_empty_list();
        send_request(pls_pkg::OP_READ,   6'd0,  32'sd0);
        send_request(pls_pkg::OP_DELETE, 6'd0,  32'sd0);
        send_request(pls_pkg::OP_CHANGE, 6'd0,  32'sd5);
        send_request(pls_pkg::OP_INSERT, 6'd1,  32'sd7);   // beyond the append slot
        send_request(pls_pkg::OP_READ,   6'd63, 32'sd0);
    endtask

    // Extreme values, front/back inserts, append, last and first delete.
    task automatic test_field_extremes();
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sh7FFF_FFFF);
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sh8000_0000);
        send_request(pls_pkg::OP_INSERT, 6'd2, -32'sd1);        // append
        send_request(pls_pkg::OP_INSERT, 6'd1, 32'sd0);
        send_request(pls_pkg::OP_READ,   6'd0, 32'sd0);
        send_request(pls_pkg::OP_READ,   6'd3, 32'sd0);
        send_request(pls_pkg::OP_CHANGE, 6'd3, 32'sh1234_5678);
        send_request(pls_pkg::OP_READ,   6'd3, 32'sh7FFF_FFFF); // value ignored on read
        send_request(pls_pkg::OP_DELETE, 6'd3, 32'sd0);         // last entry
        send_request(pls_pkg::OP_DELETE, 6'd0, 32'sd0);         // first entry
        send_request(pls_pkg::OP_READ,   6'd0, 32'sd0);
    endtask

    // Full list at a small limit, zero limit, ignored register slot, oversized limit,
    // and a limit lowered below the current count.
    task automatic test_capacity_limit();
        write_register(LIMIT_ADDR, 32'd2);
        send_request(pls_pkg::OP_INSERT, 6'd1, 32'sd11);        // list full
        write_register(LIMIT_ADDR, 32'hFFFF_FF80);     // low bits give a zero limit
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sd12);
        write_register(UNUSED_ADDR, 32'h0000_007F);    // no effect on the limit
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sd13);
        write_register(LIMIT_ADDR, 32'h0000_007F);     // clamps to the list depth
        send_request(pls_pkg::OP_INSERT, 6'd2, 32'sd77);
        write_register(LIMIT_ADDR, 32'd1);             // now below the count
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sd14);
        send_request(pls_pkg::OP_READ,   6'd2, 32'sd0);
        send_request(pls_pkg::OP_CHANGE, 6'd1, -32'sd15);
        send_request(pls_pkg::OP_DELETE, 6'd0, 32'sd0);
        send_request(pls_pkg::OP_INSERT, 6'd0, 32'sd16);
    endtask

    // Random requests that walk the list length up to the limit and back down.
    task automatic run_traffic(input int items);
        pls_pkg::t_op       op;
        logic [5:0]         pos;
        logic signed [31:0] val;
        int unsigned        roll;
        for (int n = 0; n < items; n++) begin
            if (mirror_count >= active_limit())
                growing = 1'b0;
            else if (mirror_count == 0)
                growing = 1'b1;
            roll = $urandom_range(99);
            if (growing)
                op = (roll < 50) ? pls_pkg::OP_INSERT : (roll < 65) ? pls_pkg::OP_DELETE :
                     (roll < 85) ? pls_pkg::OP_READ : pls_pkg::OP_CHANGE;
            else
                op = (roll < 15) ? pls_pkg::OP_INSERT : (roll < 55) ? pls_pkg::OP_DELETE :
                     (roll < 80) ? pls_pkg::OP_READ : pls_pkg::OP_CHANGE;
            // mostly a legal position, sometimes anywhere
            if ($urandom_range(9) < 8) begin
                if (op == pls_pkg::OP_INSERT)
                    pos = 6'($urandom_range((mirror_count > 63) ? 63 : mirror_count, 0));
                else
                    pos = (mirror_count > 0) ? 6'($urandom_range(mirror_count - 1, 0))
                                             : 6'd0;
            end else begin
                pos = 6'($urandom_range(63, 0));
            end
            case ($urandom_range(15))
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            send_request(op, pos, val);
            sender_pause();
        end
    endtask

    // Random phases under different limits and sender idling.
    task automatic test_random_traffic();
        int          phase_idle [6]  = '{0, 77, 0, 34, 77, 0};
        logic [6:0]  phase_limit [6] = '{7'd64, 7'd20, 7'd3, 7'd1, 7'd40, 7'd64};
        logic [31:0] word;
        for (int p = 0; p < 6; p++) begin
            // random upper bits: only the low seven reach the register
            word = {$urandom} & 32'hFFFF_FF80;
            write_register(LIMIT_ADDR, word | {25'd0, phase_limit[p]});
            idle_pct = phase_idle[p];
            run_traffic(PHASE_ITEMS);
        end
    endtask

    initial begin
        for (int i = 0; i < LIST_DEPTH; i++)
            list_mirror[i] = '0;
        // hold reset, then release it once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_field_extremes();
        test_capacity_limit();
        test_random_traffic();

        // wait out the last results and any trailing strobe
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Stop a hung run; the slowest legal run takes about a tenth of this.
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
